FILE: design/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

  // Hue handling
  localparam logic [8:0] FULL_TURN   = 9'd360;
  localparam logic [5:0] SECTOR_SPAN = 6'd60;

  // Unit factor 255 * 60: a channel at full value before the value multiply
  localparam logic [13:0] UNIT_FACTOR = 14'd15300;

  // Common denominator 255 * 255 * 60 of every channel fraction
  localparam logic [21:0] FRAC_DENOM = 22'd3901500;

  // Reciprocal of the denominator, scaled by two to the RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 52;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd3901500;
  localparam logic [30:0] RECIP = RECIP_FULL[30:0];

  // Reset level of the brightness limit register
  localparam logic [7:0] LIMIT_RESET = 8'd63;

  // Sixty-degree sectors of the hue circle
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  // Load enables of the per-channel scaling stages
  typedef struct packed {
    logic numer_en;
    logic prod_en;
    logic est_en;
    logic level_en;
  } chan_ctrl_t;

endpackage

`default_nettype wire

FILE: design/hsvrgb_scale.sv
// One colour channel: value multiply, brightness scaling and exact division.
`default_nettype none

module hsvrgb_scale (
  input  wire logic                    clk,
  input  wire hsvrgb_pkg::chan_ctrl_t  ctrl,
  input  wire logic [7:0]              value,
  input  wire logic [13:0]             factor,
  input  wire logic [7:0]              limit,
  output logic [7:0]                   level
);

  logic [21:0] numer;
  logic [29:0] prod;
  logic [29:0] prod_hold;
  logic [7:0]  est;
  logic [60:0] recip_prod;
  logic [29:0] est_denom;
  logic [29:0] remainder;
  logic [7:0]  level_next;

  // Form the numerator over the common denominator
  always_ff @(posedge clk) begin
    if (ctrl.numer_en) begin
      numer <= 22'(value) * 22'(factor);
    end
  end

  // Scale by the brightness limit
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= 30'(numer) * 30'(limit);
    end
  end

  // Estimate the quotient through the reciprocal; it is exact or one short
  assign recip_prod = 61'(prod) * 61'(hsvrgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.est_en) begin
      est       <= recip_prod[59:52];
      prod_hold <= prod;
    end
  end

  // Correct the estimate with one compare of the remainder
  assign est_denom = 30'(est) * 30'(hsvrgb_pkg::FRAC_DENOM);
  assign remainder = prod_hold - est_denom;
  assign level_next = (remainder >= 30'(hsvrgb_pkg::FRAC_DENOM)) ? est + 8'd1 : est;

  always_ff @(posedge clk) begin
    if (ctrl.level_en) begin
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/hsv_to_rgb_scaled_unit.sv
// Top level of the HSV to RGB converter with programmable full-scale level.
`default_nettype none

// Converts one colour per cycle from hue (degrees), saturation and value
// (unsigned, scaled like Q0.8 but with 255 = 1.0) to red, green and blue
// levels, each scaled by brightness_limit and truncated. The pipeline has
// six register stages; a result stays on the output until it is taken.
// One transaction is taken every cycle while the output side keeps up;
// bubbles are squeezed out when the output stalls. The stages are the
// sector split, the factor select and the chain of multiplies: value times
// factor, times the limit, times the reciprocal of the denominator, and the
// final correction. Hue above 359 wraps round the circle. Write
// brightness_limit (reset 63) only while no colour is in flight.
module hsv_to_rgb_scaled_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // hue[8:0], saturation[16:9], value[24:17], zero
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  logic [7:0] brightness_limit;

  // stage valid bits and load enables, stage 1 first
  logic [6:1] vld;
  logic [6:1] adv;

  logic [8:0] hue_in;
  logic [7:0] sat_in;
  logic [7:0] val_in;
  logic [8:0] hue_red;
  hsvrgb_pkg::sector_t sector_next;
  logic [8:0] base_next;
  logic [8:0] rem_wide;

  // stage 1 registers
  hsvrgb_pkg::sector_t sector;
  logic [5:0] rem;
  logic [7:0] sat1;
  logic [7:0] val1;

  // stage 2 registers
  logic [7:0]  val2;
  logic [13:0] fac_r;
  logic [13:0] fac_g;
  logic [13:0] fac_b;

  logic [13:0] rem_sat;
  logic [13:0] crem_sat;
  logic [13:0] f_v;
  logic [13:0] f_p;
  logic [13:0] f_q;
  logic [13:0] f_t;
  logic [13:0] fac_r_next;
  logic [13:0] fac_g_next;
  logic [13:0] fac_b_next;

  hsvrgb_pkg::chan_ctrl_t chan_ctrl;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  // Hold the brightness limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_limit <= hsvrgb_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      brightness_limit <= cfg_wdata;
    end
  end

  // Advance each stage when it is empty or the next one moves
  assign adv[6] = !vld[6] || m_axis_tready;
  assign adv[5] = !vld[5] || adv[6];
  assign adv[4] = !vld[4] || adv[5];
  assign adv[3] = !vld[3] || adv[4];
  assign adv[2] = !vld[2] || adv[3];
  assign adv[1] = !vld[1] || adv[2];

  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= s_axis_tvalid;
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
      if (adv[5]) vld[5] <= vld[4];
      if (adv[6]) vld[6] <= vld[5];
    end
  end

  // Unpack the input transaction
  assign hue_in = s_axis_tdata[8:0];
  assign sat_in = s_axis_tdata[16:9];
  assign val_in = s_axis_tdata[24:17];

  // Wrap the hue and find its sector and remainder
  assign hue_red = (hue_in >= hsvrgb_pkg::FULL_TURN) ? hue_in - hsvrgb_pkg::FULL_TURN : hue_in;

  always_comb begin
    priority if (hue_red >= 9'd300) begin
      sector_next = hsvrgb_pkg::SEC_MAGENTA_RED;
      base_next   = 9'd300;
    end else if (hue_red >= 9'd240) begin
      sector_next = hsvrgb_pkg::SEC_BLUE_MAGENTA;
      base_next   = 9'd240;
    end else if (hue_red >= 9'd180) begin
      sector_next = hsvrgb_pkg::SEC_CYAN_BLUE;
      base_next   = 9'd180;
    end else if (hue_red >= 9'd120) begin
      sector_next = hsvrgb_pkg::SEC_GREEN_CYAN;
      base_next   = 9'd120;
    end else if (hue_red >= 9'd60) begin
      sector_next = hsvrgb_pkg::SEC_YELLOW_GREEN;
      base_next   = 9'd60;
    end else begin
      sector_next = hsvrgb_pkg::SEC_RED_YELLOW;
      base_next   = 9'd0;
    end
  end

  assign rem_wide = hue_red - base_next;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sector <= sector_next;
      rem    <= rem_wide[5:0];
      sat1   <= sat_in;
      val1   <= val_in;
    end
  end

  // Form the v, p, q and t factors over 255 * 60
  assign rem_sat  = 14'(rem) * 14'(sat1);
  assign crem_sat = 14'(hsvrgb_pkg::SECTOR_SPAN - rem) * 14'(sat1);
  assign f_v = hsvrgb_pkg::UNIT_FACTOR;
  assign f_p = 14'(8'd255 - sat1) * 14'(hsvrgb_pkg::SECTOR_SPAN);
  assign f_q = hsvrgb_pkg::UNIT_FACTOR - rem_sat;
  assign f_t = hsvrgb_pkg::UNIT_FACTOR - crem_sat;

  // Select the channel mix of the sector
  always_comb begin
    unique case (sector)
      hsvrgb_pkg::SEC_RED_YELLOW: begin
        fac_r_next = f_v; fac_g_next = f_t; fac_b_next = f_p;
      end
      hsvrgb_pkg::SEC_YELLOW_GREEN: begin
        fac_r_next = f_q; fac_g_next = f_v; fac_b_next = f_p;
      end
      hsvrgb_pkg::SEC_GREEN_CYAN: begin
        fac_r_next = f_p; fac_g_next = f_v; fac_b_next = f_t;
      end
      hsvrgb_pkg::SEC_CYAN_BLUE: begin
        fac_r_next = f_p; fac_g_next = f_q; fac_b_next = f_v;
      end
      hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
        fac_r_next = f_t; fac_g_next = f_p; fac_b_next = f_v;
      end
      default: begin
        fac_r_next = f_v; fac_g_next = f_p; fac_b_next = f_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      val2  <= val1;
      fac_r <= fac_r_next;
      fac_g <= fac_g_next;
      fac_b <= fac_b_next;
    end
  end

  // Drive the scaling stages of the three channels
  assign chan_ctrl.numer_en = adv[3];
  assign chan_ctrl.prod_en  = adv[4];
  assign chan_ctrl.est_en   = adv[5];
  assign chan_ctrl.level_en = adv[6];

  hsvrgb_scale u_scale_red (
    .clk    (clk),
    .ctrl   (chan_ctrl),
    .value  (val2),
    .factor (fac_r),
    .limit  (brightness_limit),
    .level  (red)
  );

  hsvrgb_scale u_scale_green (
    .clk    (clk),
    .ctrl   (chan_ctrl),
    .value  (val2),
    .factor (fac_g),
    .limit  (brightness_limit),
    .level  (green)
  );

  hsvrgb_scale u_scale_blue (
    .clk    (clk),
    .ctrl   (chan_ctrl),
    .value  (val2),
    .factor (fac_b),
    .limit  (brightness_limit),
    .level  (blue)
  );

  assign m_axis_tdata = {blue, green, red};

  // Check the sector split and the output range
  a_rem_in_span: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (rem < hsvrgb_pkg::SECTOR_SPAN))
    else $error("hue remainder out of sector span");

  a_sector_known: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (sector <= hsvrgb_pkg::SEC_MAGENTA_RED))
    else $error("hue sector out of range");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (red <= brightness_limit && green <= brightness_limit
                && blue <= brightness_limit))
    else $error("channel level above brightness limit");

endmodule

`default_nettype wire
